// ===== src/tfv_pkg.sv =====
// ----------------------------------------------------------------------------
// tfv_pkg
// Shared constants, status codes and types for the frame validator.
// ----------------------------------------------------------------------------
package tfv_pkg;

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    localparam logic [7:0] MARKER_VALUE = 8'h01;
    localparam logic [4:0] MUX_HDR_LEN  = 5'd5;
    localparam logic [4:0] CTRL_HDR_LEN = 5'd11;
    localparam logic [4:0] SERV_HDR_LEN = 5'd12;

    // Byte positions of the TLV length field and of the first TLV byte
    localparam logic [POS_W-1:0] CTRL_TLV_LEN_POS = POS_W'(10);
    localparam logic [POS_W-1:0] SERV_TLV_LEN_POS = POS_W'(11);
    localparam logic [POS_W-1:0] CTRL_TLV_START   = POS_W'(12);
    localparam logic [POS_W-1:0] SERV_TLV_START   = POS_W'(13);

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_MARKER      = 3'd1;
    localparam logic [2:0] STATUS_TRUNCATED   = 3'd2;
    localparam logic [2:0] STATUS_MUX_SHORT   = 3'd3;
    localparam logic [2:0] STATUS_LEN_MISMATCH = 3'd4;
    localparam logic [2:0] STATUS_HDR_SHORT   = 3'd5;
    localparam logic [2:0] STATUS_TLV_SUM     = 3'd6;
    localparam logic [2:0] STATUS_TLV_OVERRUN = 3'd7;

    typedef enum logic [1:0] {
        TLV_TYPE   = 2'd0,
        TLV_LEN_LO = 2'd1,
        TLV_LEN_HI = 2'd2,
        TLV_VALUE  = 2'd3
    } tlv_phase_t;

    typedef struct packed {
        logic advance;
        logic clear;
    } tlv_ctrl_t;

endpackage

// ===== src/tfv_if.sv =====
// ----------------------------------------------------------------------------
// tfv_if
// Byte stream and result channels of the frame validator.
// ----------------------------------------------------------------------------
interface tfv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfv_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        overrun_in_value;
    logic [7:0]  mux_flags;
    logic [7:0]  service;
    logic [7:0]  client;
    logic [7:0]  msg_flags;
    logic [15:0] transaction;
    logic [15:0] message_id;

    modport source (
        output valid, output status, output overrun_in_value, output mux_flags,
        output service, output client, output msg_flags, output transaction,
        output message_id, input ready
    );
    modport sink (
        input valid, input status, input overrun_in_value, input mux_flags,
        input service, input client, input msg_flags, input transaction,
        input message_id, output ready
    );
endinterface

// ===== src/tfv_tlv_walk.sv =====
// ----------------------------------------------------------------------------
// tfv_tlv_walk
// Tracks the type / length / value phase of the TLV list byte by byte.
// ----------------------------------------------------------------------------
module tfv_tlv_walk (
    input  logic                clk,
    input  logic                rst_n,
    input  tfv_pkg::tlv_ctrl_t  ctl,
    input  logic [7:0]          data_byte,
    output tfv_pkg::tlv_phase_t phase_next
);
    import tfv_pkg::*;

    tlv_phase_t  phase_reg;
    logic [15:0] left_reg;
    logic [7:0]  len_lo_reg;

    tlv_phase_t  step_phase;
    logic [15:0] step_left;
    logic [7:0]  step_len_lo;
    logic [15:0] full_len;
    logic [15:0] left_dec;

    assign full_len = {data_byte, len_lo_reg};
    assign left_dec = left_reg - 16'd1;

    always_comb
    begin
        step_phase  = phase_reg;
        step_left   = left_reg;
        step_len_lo = len_lo_reg;
        unique case (phase_reg)
            TLV_TYPE:
            begin
                step_phase = TLV_LEN_LO;
            end
            TLV_LEN_LO:
            begin
                step_len_lo = data_byte;
                step_phase  = TLV_LEN_HI;
            end
            TLV_LEN_HI:
            begin
                step_left  = full_len;
                step_phase = (full_len != 16'd0) ? TLV_VALUE : TLV_TYPE;
            end
            TLV_VALUE:
            begin
                step_left  = left_dec;
                step_phase = (left_dec == 16'd0) ? TLV_TYPE : TLV_VALUE;
            end
            default:
            begin
                step_phase = TLV_TYPE;
            end
        endcase
    end

    assign phase_next = ctl.advance ? step_phase : phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= TLV_TYPE;
            left_reg   <= '0;
            len_lo_reg <= '0;
        end
        else if (ctl.clear)
        begin
            phase_reg  <= TLV_TYPE;
            left_reg   <= '0;
            len_lo_reg <= '0;
        end
        else if (ctl.advance)
        begin
            phase_reg  <= step_phase;
            left_reg   <= step_left;
            len_lo_reg <= step_len_lo;
        end
    end

endmodule

// ===== src/tlv_frame_validator_unit.sv =====
// ----------------------------------------------------------------------------
// tlv_frame_validator_unit
// Streams a framed TLV message and reports header fields and frame checks.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; bytes keep flowing while a verdict waits,
//   only a last byte holds until the result register is free.
// Result: the verdict is registered and appears in the cycle after the last-byte transfer.
// Reset: all frame state clears to zero; frame state also clears after each
//   last byte.
// ----------------------------------------------------------------------------
module tlv_frame_validator_unit (
    input logic         clk,
    input logic         rst_n,
    tfv_byte_if.sink    frame,
    tfv_result_if.source result
);
    import tfv_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic             marker_bad_reg;
    logic [15:0]      mux_length_reg;
    logic [63:0]      header_reg;
    logic [15:0]      tlv_total_reg;
    logic             out_valid_reg;

    logic [POS_W-1:0] pos_next;
    logic             marker_bad_next;
    logic [15:0]      mux_length_next;
    logic [63:0]      header_next;
    logic [15:0]      tlv_total_next;

    logic             accept;
    logic             is_last;
    logic             ctrl;
    logic [POS_W-1:0] tlv_len_pos;
    logic [POS_W-1:0] tlv_start;
    logic [4:0]       hdr_len;
    tlv_ctrl_t        tlv_ctl;
    tlv_phase_t       phase_next;

    logic [2:0]       status_c;
    logic             in_value_c;
    logic [15:0]      trans_c;
    logic [15:0]      msg_c;

    // Only a last byte needs the result register; hold it while a verdict waits
    assign frame.ready = !out_valid_reg || result.ready || !frame.last_byte;
    assign accept      = frame.valid && frame.ready;
    assign is_last     = frame.last_byte;

    // Header type comes from the service byte held before this transfer
    assign ctrl        = (header_reg[15:8] == 8'd0);
    assign tlv_len_pos = ctrl ? CTRL_TLV_LEN_POS : SERV_TLV_LEN_POS;
    assign tlv_start   = ctrl ? CTRL_TLV_START : SERV_TLV_START;
    assign hdr_len     = ctrl ? CTRL_HDR_LEN : SERV_HDR_LEN;

    assign tlv_ctl.advance = accept && (pos_reg >= tlv_start);
    assign tlv_ctl.clear   = accept && is_last;

    tfv_tlv_walk u_tlv_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (tlv_ctl),
        .data_byte  (frame.data_byte),
        .phase_next (phase_next)
    );

    always_comb
    begin
        marker_bad_next = marker_bad_reg;
        mux_length_next = mux_length_reg;
        header_next     = header_reg;
        tlv_total_next  = tlv_total_reg;

        if (pos_reg == POS_W'(0))
            marker_bad_next = (frame.data_byte != MARKER_VALUE);
        if (pos_reg == POS_W'(1))
            mux_length_next[7:0] = frame.data_byte;
        if (pos_reg == POS_W'(2))
            mux_length_next[15:8] = frame.data_byte;
        for (int k = 0; k < 8; k++)
        begin
            if (pos_reg == POS_W'(k + 3))
                header_next[k*8 +: 8] = frame.data_byte;
        end
        if (pos_reg == tlv_len_pos)
            tlv_total_next[7:0] = frame.data_byte;
        if (pos_reg == tlv_len_pos + POS_W'(1))
            tlv_total_next[15:8] = frame.data_byte;

        pos_next = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_W'(1);
    end

    // Frame verdict: first failing check wins
    always_comb
    begin
        status_c   = STATUS_OK;
        in_value_c = 1'b0;
        if (marker_bad_next)
            status_c = STATUS_MARKER;
        else if (pos_reg < POS_W'(2))
            status_c = STATUS_TRUNCATED;
        else if (mux_length_next < 16'(MUX_HDR_LEN))
            status_c = STATUS_MUX_SHORT;
        else if (POS_W'(mux_length_next) != pos_reg)
            status_c = STATUS_LEN_MISMATCH;
        else if (mux_length_next < 16'(hdr_len))
            status_c = STATUS_HDR_SHORT;
        else if (mux_length_next - 16'(hdr_len) != tlv_total_next)
            status_c = STATUS_TLV_SUM;
        else if (phase_next == TLV_LEN_LO || phase_next == TLV_LEN_HI)
            status_c = STATUS_TLV_OVERRUN;
        else if (phase_next == TLV_VALUE)
        begin
            status_c   = STATUS_TLV_OVERRUN;
            in_value_c = 1'b1;
        end

        if (ctrl)
        begin
            trans_c = {8'd0, header_next[39:32]};
            msg_c   = header_next[55:40];
        end
        else
        begin
            trans_c = header_next[47:32];
            msg_c   = header_next[63:48];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            marker_bad_reg <= 1'b0;
            mux_length_reg <= '0;
            header_reg     <= '0;
            tlv_total_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept && is_last)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (accept)
            begin
                if (is_last)
                begin
                    // Drop all frame state after the last byte
                    pos_reg        <= '0;
                    marker_bad_reg <= 1'b0;
                    mux_length_reg <= '0;
                    header_reg     <= '0;
                    tlv_total_reg  <= '0;
                end
                else
                begin
                    pos_reg        <= pos_next;
                    marker_bad_reg <= marker_bad_next;
                    mux_length_reg <= mux_length_next;
                    header_reg     <= header_next;
                    tlv_total_reg  <= tlv_total_next;
                end
            end
        end
    end

    // Result payload, loaded on the last-byte transfer
    always_ff @(posedge clk)
    begin
        if (accept && is_last)
        begin
            result.status           <= status_c;
            result.overrun_in_value <= in_value_c;
            result.mux_flags        <= header_next[7:0];
            result.service          <= header_next[15:8];
            result.client           <= header_next[23:16];
            result.msg_flags        <= header_next[31:24];
            result.transaction      <= trans_c;
            result.message_id       <= msg_c;
        end
    end

    assign result.valid = out_valid_reg;

endmodule

// ===== dv/tfv_frame_checker.sv =====
// ----------------------------------------------------------------------------
// tfv_frame_checker
// Watches the byte and result channels of the frame validator, predicts the
// verdict of every frame from the accepted bytes and compares each result
// field by field against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module tfv_frame_checker (
    input  logic  clk,
    input  logic  rst_n,
    tfv_byte_if   frame,
    tfv_result_if result,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tfv_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic        overrun_in_value;
        logic [7:0]  mux_flags;
        logic [7:0]  service;
        logic [7:0]  client;
        logic [7:0]  msg_flags;
        logic [15:0] transaction;
        logic [15:0] message_id;
    } verdict_t;

    logic [POS_W-1:0] pos_r;
    logic             marker_bad_r;
    logic [15:0]      mux_len_r;
    logic [63:0]      hdr_r;        // bytes 3..10, byte 3 in the low bits
    logic [15:0]      tlv_len_r;
    tlv_phase_t       phase_r;
    logic [15:0]      left_r;
    logic [7:0]       len_lo_r;
    verdict_t         verdict_q[$];

    task automatic clear_frame();
        pos_r        = '0;
        marker_bad_r = 1'b0;
        mux_len_r    = '0;
        hdr_r        = '0;
        tlv_len_r    = '0;
        phase_r      = TLV_TYPE;
        left_r       = '0;
        len_lo_r     = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic is_last);
        logic             ctrl;
        logic [POS_W-1:0] len_pos;
        logic [POS_W-1:0] tlv_start;
        int               p;
        int               flen;
        int               hlen;
        verdict_t         v;
        // service type is taken from what arrived before this byte
        ctrl      = (hdr_r[15:8] == 8'h00);
        len_pos   = ctrl ? CTRL_TLV_LEN_POS : SERV_TLV_LEN_POS;
        tlv_start = ctrl ? CTRL_TLV_START : SERV_TLV_START;
        p         = int'(pos_r);

        if (p == 0)
            marker_bad_r = (b != MARKER_VALUE);
        else if (p == 1)
            mux_len_r[7:0] = b;
        else if (p == 2)
            mux_len_r[15:8] = b;
        else if (p <= 10)
            hdr_r[(p-3)*8 +: 8] = b;

        if (pos_r == len_pos)
            tlv_len_r[7:0] = b;
        else if (pos_r == len_pos + 1'b1)
            tlv_len_r[15:8] = b;

        if (pos_r >= tlv_start)
        begin
            case (phase_r)
                TLV_TYPE:   phase_r = TLV_LEN_LO;
                TLV_LEN_LO:
                begin
                    len_lo_r = b;
                    phase_r  = TLV_LEN_HI;
                end
                TLV_LEN_HI:
                begin
                    left_r  = {b, len_lo_r};
                    phase_r = (left_r != 0) ? TLV_VALUE : TLV_TYPE;
                end
                default:
                begin
                    left_r = left_r - 1'b1;
                    if (left_r == 0)
                        phase_r = TLV_TYPE;
                end
            endcase
        end

        if (!is_last)
        begin
            // saturate on very long frames
            if (pos_r != POS_MAX)
                pos_r = pos_r + 1'b1;
            return;
        end

        flen = p + 1;
        hlen = ctrl ? int'(CTRL_HDR_LEN) : int'(SERV_HDR_LEN);
        v    = '0;
        if (marker_bad_r)
            v.status = STATUS_MARKER;
        else if (flen < 3)
            v.status = STATUS_TRUNCATED;
        else if (mux_len_r < MUX_HDR_LEN)
            v.status = STATUS_MUX_SHORT;
        else if (int'(mux_len_r) != flen - 1)
            v.status = STATUS_LEN_MISMATCH;
        else if (int'(mux_len_r) < hlen)
            v.status = STATUS_HDR_SHORT;
        else if (int'(mux_len_r) - hlen != int'(tlv_len_r))
            v.status = STATUS_TLV_SUM;
        else if (phase_r == TLV_LEN_LO || phase_r == TLV_LEN_HI)
            v.status = STATUS_TLV_OVERRUN;
        else if (phase_r == TLV_VALUE)
        begin
            v.status           = STATUS_TLV_OVERRUN;
            v.overrun_in_value = 1'b1;
        end
        else
            v.status = STATUS_OK;

        v.mux_flags = hdr_r[7:0];
        v.service   = hdr_r[15:8];
        v.client    = hdr_r[23:16];
        v.msg_flags = hdr_r[31:24];
        if (ctrl)
        begin
            v.transaction = {8'h00, hdr_r[39:32]};
            v.message_id  = hdr_r[55:40];
        end
        else
        begin
            v.transaction = hdr_r[47:32];
            v.message_id  = hdr_r[63:48];
        end
        verdict_q.push_back(v);
        clear_frame();
    endtask

    task automatic check_field(input string name, input logic [15:0] expv,
                               input logic [15:0] actv);
        if (actv !== expv)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, expv, actv);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
        clear_frame();
    end

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (!rst_n)
        begin
            clear_frame();
            verdict_q.delete();
        end
        else
        begin
            if (frame.valid && frame.ready)
                predict_byte(frame.data_byte, frame.last_byte);
            if (result.valid && result.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transfer with no frame outstanding");
                    fail_count++;
                end
                else
                begin
                    exp_v = verdict_q.pop_front();
                    check_field("status", 16'(exp_v.status), 16'(result.status));
                    check_field("overrun_in_value", 16'(exp_v.overrun_in_value),
                                16'(result.overrun_in_value));
                    check_field("mux_flags", 16'(exp_v.mux_flags), 16'(result.mux_flags));
                    check_field("service", 16'(exp_v.service), 16'(result.service));
                    check_field("client", 16'(exp_v.client), 16'(result.client));
                    check_field("msg_flags", 16'(exp_v.msg_flags), 16'(result.msg_flags));
                    check_field("transaction", exp_v.transaction, result.transaction);
                    check_field("message_id", exp_v.message_id, result.message_id);
                end
            end
        end
        pending = verdict_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives framed TLV messages into the frame validator: a directed set of
// corner frames, then random well-formed and flawed frames under several
// sender/receiver idle mixes. The checker module does the prediction and
// comparison; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tfv_pkg::*;

    localparam int RAND_BYTES = 1400;

    typedef enum int {
        FLAW_NONE,
        FLAW_MARKER,
        FLAW_CUT,
        FLAW_EXTRA,
        FLAW_MUX_LEN,
        FLAW_TLV_SUM,
        FLAW_HDR_OVR,
        FLAW_VAL_OVR,
        FLAW_SHORT_HDR,
        FLAW_NOISE
    } flaw_t;

    logic       clk;
    logic       rst_n;
    int         fail_count;
    int         pending;
    int         idle_pct;
    int         stall_pct;
    int         bytes_sent;
    int         hold_left;
    bit         hold_req;
    logic [7:0] frame_bytes[$];

    tfv_byte_if   frame_ch ();
    tfv_result_if result_ch ();

    tlv_frame_validator_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    tfv_frame_checker verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("tlv_frame_validator_unit test failed");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        hold_left       = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [7:0] hdr_fill(input bit all_ones);
        return all_ones ? 8'hFF : 8'($urandom);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(negedge clk);
        end
        frame_ch.valid     <= 1'b1;
        frame_ch.data_byte <= b;
        frame_ch.last_byte <= is_last;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // Drop valid and hold until every outstanding verdict has come back
    task automatic drain();
        frame_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic build_frame(input bit ctrl, input int n_tlv, input flaw_t flaw,
                               input bit all_ones);
        logic [7:0]  body[$];
        logic [15:0] mux;
        logic [15:0] tsum;
        logic [15:0] vlen;
        int          flen;
        frame_bytes.delete();
        if (flaw == FLAW_NOISE)
        begin
            repeat ($urandom_range(1, 20))
                frame_bytes.push_back(8'($urandom));
            if ($urandom_range(0, 1))
                frame_bytes[0] = MARKER_VALUE;
            return;
        end

        repeat (n_tlv)
        begin
            vlen = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(256, 300))
                                                : 16'($urandom_range(0, 6));
            body.push_back(8'($urandom));
            body.push_back(vlen[7:0]);
            body.push_back(vlen[15:8]);
            repeat (vlen)
                body.push_back(8'($urandom));
        end
        // end inside a TLV header
        if (flaw == FLAW_HDR_OVR)
        begin
            body.push_back(8'($urandom));
            if ($urandom_range(0, 1))
                body.push_back(8'($urandom));
        end
        // end inside a TLV value
        if (flaw == FLAW_VAL_OVR)
        begin
            vlen = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(1, 20));
            body.push_back(8'($urandom));
            body.push_back(vlen[7:0]);
            body.push_back(vlen[15:8]);
            repeat ($urandom_range(0, (vlen > 6) ? 6 : int'(vlen) - 1))
                body.push_back(8'($urandom));
        end

        tsum = 16'(body.size());
        mux  = 16'(body.size()) + (ctrl ? 16'(CTRL_HDR_LEN) : 16'(SERV_HDR_LEN));
        if (flaw == FLAW_TLV_SUM)
            tsum = tsum + 16'($urandom_range(1, 16'hFFFF));
        if (flaw == FLAW_MUX_LEN)
            mux = mux + 16'($urandom_range(1, 16'hFFFF));

        frame_bytes.push_back(MARKER_VALUE);
        frame_bytes.push_back(mux[7:0]);
        frame_bytes.push_back(mux[15:8]);
        frame_bytes.push_back(hdr_fill(all_ones));
        frame_bytes.push_back(ctrl ? 8'h00 : (all_ones ? 8'hFF : 8'($urandom_range(1, 255))));
        frame_bytes.push_back(hdr_fill(all_ones));
        frame_bytes.push_back(hdr_fill(all_ones));
        frame_bytes.push_back(hdr_fill(all_ones));
        if (!ctrl)
            frame_bytes.push_back(hdr_fill(all_ones));
        frame_bytes.push_back(hdr_fill(all_ones));
        frame_bytes.push_back(hdr_fill(all_ones));
        frame_bytes.push_back(tsum[7:0]);
        frame_bytes.push_back(tsum[15:8]);
        foreach (body[i])
            frame_bytes.push_back(body[i]);

        case (flaw)
            FLAW_MARKER:
                frame_bytes[0] = MARKER_VALUE ^ 8'($urandom_range(1, 255));
            FLAW_CUT:
            begin
                flen = $urandom_range(1, frame_bytes.size() - 1);
                while (frame_bytes.size() > flen)
                    void'(frame_bytes.pop_back());
            end
            FLAW_EXTRA:
                repeat ($urandom_range(1, 3))
                    frame_bytes.push_back(8'($urandom));
            FLAW_SHORT_HDR:
            begin
                // consistent mux length, but the header itself is cut short
                flen = $urandom_range(6, ctrl ? 11 : 12);
                while (frame_bytes.size() > flen)
                    void'(frame_bytes.pop_back());
                frame_bytes[1] = 8'(flen - 1);
                frame_bytes[2] = 8'h00;
            end
            default: ;
        endcase
    endtask

    task automatic random_frame();
        int    r;
        flaw_t flaw;
        r = $urandom_range(0, 19);
        case (r)
            8:       flaw = FLAW_MARKER;
            9:       flaw = FLAW_CUT;
            10:      flaw = FLAW_EXTRA;
            11:      flaw = FLAW_MUX_LEN;
            12:      flaw = FLAW_TLV_SUM;
            13, 14:  flaw = FLAW_HDR_OVR;
            15, 16:  flaw = FLAW_VAL_OVR;
            17:      flaw = FLAW_SHORT_HDR;
            18:      flaw = FLAW_NOISE;
            default: flaw = FLAW_NONE;
        endcase
        build_frame($urandom_range(0, 1), $urandom_range(0, 3), flaw,
                    $urandom_range(0, 15) == 0);
        send_frame();
    endtask

    initial
    begin
        frame_ch.valid     = 1'b0;
        frame_ch.data_byte = 8'h00;
        frame_ch.last_byte = 1'b0;
        idle_pct           = 0;
        stall_pct          = 0;
        bytes_sent         = 0;
        hold_req           = 1'b0;
        rst_n              = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corner frames
        frame_bytes = '{8'h01};
        send_frame();
        frame_bytes = '{8'h00, 8'hFF};
        send_frame();
        frame_bytes = '{8'h01, 8'h02};
        send_frame();
        frame_bytes = '{8'h01, 8'h02, 8'h00};
        send_frame();
        // frame ends on the service byte
        frame_bytes = '{8'h01, 8'h04, 8'h00, 8'hAA, 8'h07};
        send_frame();
        frame_bytes = '{8'h01, 8'h05, 8'h00, 8'hFF, 8'hFF, 8'hFF};
        send_frame();
        frame_bytes = '{8'h01, 8'hFF, 8'hFF, 8'h00};
        send_frame();
        build_frame(1'b1, 0, FLAW_NONE, 1'b0);
        send_frame();
        build_frame(1'b0, 2, FLAW_NONE, 1'b1);
        send_frame();
        build_frame(1'b1, 1, FLAW_NONE, 1'b1);
        send_frame();
        build_frame(1'b1, 1, FLAW_VAL_OVR, 1'b0);
        send_frame();
        build_frame(1'b0, 0, FLAW_VAL_OVR, 1'b0);
        send_frame();
        build_frame(1'b1, 2, FLAW_HDR_OVR, 1'b0);
        send_frame();
        build_frame(1'b0, 1, FLAW_HDR_OVR, 1'b0);
        send_frame();
        build_frame(1'b0, 1, FLAW_TLV_SUM, 1'b0);
        send_frame();
        build_frame(1'b1, 1, FLAW_MUX_LEN, 1'b0);
        send_frame();
        build_frame(1'b1, 0, FLAW_SHORT_HDR, 1'b0);
        send_frame();
        build_frame(1'b0, 0, FLAW_SHORT_HDR, 1'b0);
        send_frame();
        build_frame(1'b0, 2, FLAW_CUT, 1'b0);
        send_frame();
        build_frame(1'b1, 1, FLAW_EXTRA, 1'b0);
        send_frame();
        build_frame(1'b0, 1, FLAW_MARKER, 1'b0);
        send_frame();
        drain();

        // Hold the receiver off while frames keep coming, so the input stalls
        hold_req = 1'b1;
        repeat (10)
        begin
            build_frame($urandom_range(0, 1), 1, FLAW_NONE, 1'b0);
            send_frame();
        end
        drain();

        bytes_sent = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 72;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 72;
                end
                default:
                begin
                    idle_pct  = 14;
                    stall_pct = 14;
                end
            endcase
            while (bytes_sent < (ph + 1) * RAND_BYTES / 4)
                random_frame();
        end

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tlv_frame_validator_unit test passed");
        else
            $display("tlv_frame_validator_unit test failed");
        $finish;
    end

endmodule
